FILE: hw/rtl/wdtp_pkg.sv
// wdtp_pkg: shared types, codes and constants for the watchdog timer with prescaler
// used by watchdog_timer_with_prescaler; no dependencies
`default_nettype none

package wdtp_pkg;

   localparam int COUNTER_BITS_DEF  = 16;
   localparam int PRESCALE_BITS_DEF = 8;

   localparam int DATA_BITS   = 16;
   localparam int DIV_BITS    = 7;
   localparam int RESET_COUNT = 32768;

   // request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // register numbers
   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_RELOAD  = 2'd1;
   localparam logic [1:0] REG_COUNTER = 2'd2;

   // control word bit positions
   localparam int CTL_RESET_EN  = 0;
   localparam int CTL_IRQ_EN    = 2;
   localparam int CTL_DIV_LSB   = 3;
   localparam int CTL_ENABLE    = 5;
   localparam int CTL_PRE_LSB   = 8;
   localparam int CTL_PRE_BITS  = 8;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [1:0]           reg_sel;
      logic [DATA_BITS-1:0] write_value;
   } wdtp_req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_value;
      logic                 irq_pulse;
      logic                 reset_pulse;
   } wdtp_rsp_type;

   // last divider count before wrap: 15, 31, 63 or 127
   function automatic logic [DIV_BITS-1:0] div_limit(input logic [1:0] sel);
      logic [DIV_BITS-1:0] lim;
      case (sel)
         2'd0:    lim = 7'd15;
         2'd1:    lim = 7'd31;
         2'd2:    lim = 7'd63;
         2'd3:    lim = 7'd127;
         default: lim = 7'd127;
      endcase
      return lim;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/watchdog_timer_with_prescaler.sv
// watchdog_timer_with_prescaler: register file, prescaler, divider and down counter
// depends on wdtp_pkg
`default_nettype none

// usage
// req channel: one transaction per peripheral clock tick or register access
//   (req_type tick, read or write; reg_sel picks control, reload or counter)
// rsp channel: exactly one transaction per request, in order, carrying the
//   read data and the interrupt and reset pulses for that request
// response path: a request accepted at one edge has its response in the output
//   register after that edge, or in the skid entry if that register still holds an untaken response
// throughput: one request per cycle while req_stall is low; state is updated in the
//   same cycle the request is taken, so back-to-back ticks count at full rate
// stalls: an output register plus one skid entry sit on the rsp side;
//   req_stall rises only once the skid entry is occupied, and is a register
// reset: synchronous, active high; control clears (timer stopped), reload and
//   counter load 32768, prescaler and divider clear, both response entries
//   empty
module watchdog_timer_with_prescaler
   import wdtp_pkg::*;
#(
   parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
   parameter int PRESCALE_BITS = PRESCALE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire wdtp_req_type req,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      wdtp_rsp_type rsp
);

   localparam int CntLow = (COUNTER_BITS < DATA_BITS) ? COUNTER_BITS : DATA_BITS;
   localparam int PreLow = (PRESCALE_BITS < CTL_PRE_BITS) ? PRESCALE_BITS : CTL_PRE_BITS;

   logic [DATA_BITS-1:0]     ctl_ff, ctl_in;
   logic [COUNTER_BITS-1:0]  reload_ff, reload_in;
   logic [COUNTER_BITS-1:0]  count_ff, count_in;
   logic [PRESCALE_BITS-1:0] pre_ff, pre_in;
   logic [DIV_BITS-1:0]      div_ff, div_in;

   wdtp_rsp_type out_ff, out_in;
   wdtp_rsp_type skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;

   wdtp_rsp_type             res;
   logic                     in_fire;
   logic                     out_fire;
   logic [PRESCALE_BITS-1:0] pre_limit;
   logic [DIV_BITS-1:0]      dlim;

   assign in_fire   = req_valid && !skid_valid_ff;
   assign out_fire  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   assign pre_limit = PRESCALE_BITS'(ctl_ff[CTL_PRE_LSB +: PreLow]);
   assign dlim      = div_limit(ctl_ff[CTL_DIV_LSB +: 2]);

   // request processing
   always_comb begin
      ctl_in    = ctl_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      pre_in    = pre_ff;
      div_in    = div_ff;
      res       = '0;
      case (req.req_type)
         REQ_TICK: begin
            if (ctl_ff[CTL_ENABLE]) begin
               if (pre_ff < pre_limit) begin
                  pre_in = pre_ff + 1'b1;
               end else begin
                  pre_in = '0;
                  if (div_ff < dlim) begin
                     div_in = div_ff + 1'b1;
                  end else begin
                     div_in = '0;
                     if (count_ff <= COUNTER_BITS'(1)) begin
                        count_in        = reload_ff;
                        res.irq_pulse   = ctl_ff[CTL_IRQ_EN];
                        res.reset_pulse = ctl_ff[CTL_RESET_EN];
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
            end
         end
         REQ_READ: begin
            case (req.reg_sel)
               REG_CONTROL: res.read_value = ctl_ff;
               REG_RELOAD:  res.read_value = DATA_BITS'(reload_ff[CntLow-1:0]);
               REG_COUNTER: res.read_value = DATA_BITS'(count_ff[CntLow-1:0]);
               default:     res.read_value = '0;
            endcase
         end
         REQ_WRITE: begin
            case (req.reg_sel)
               REG_CONTROL: ctl_in    = req.write_value;
               REG_RELOAD:  reload_in = COUNTER_BITS'(req.write_value[CntLow-1:0]);
               REG_COUNTER: count_in  = COUNTER_BITS'(req.write_value[CntLow-1:0]);
               default:     ;
            endcase
         end
         default: ;
      endcase
   end

   // output register and skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff || out_fire) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= '0;
         reload_ff     <= COUNTER_BITS'(RESET_COUNT);
         count_ff      <= COUNTER_BITS'(RESET_COUNT);
         pre_ff        <= '0;
         div_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (in_fire) begin
            ctl_ff    <= ctl_in;
            reload_ff <= reload_in;
            count_ff  <= count_in;
            pre_ff    <= pre_in;
            div_ff    <= div_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a transaction while the output register is empty");

   a_pulse_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.irq_pulse || out_ff.reset_pulse)) |-> out_ff.read_value == '0)
      else $error("expiry pulse carries read data");

   a_disabled_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl_ff[CTL_ENABLE] && !in_fire) |=> ($stable(pre_ff) && $stable(div_ff)))
      else $error("prescaler or divider moved while timer disabled");

   a_non_tick_hold: assert property (@(posedge clock) disable iff (reset)
      (in_fire && req.req_type != REQ_TICK) |=> ($stable(pre_ff) && $stable(div_ff)))
      else $error("register access advanced prescaler or divider");
`endif

endmodule

`default_nettype wire
